// ===== design/sfr_pkg.sv =====
// Shared constants, register codes and types for the stream find-and-replace block.
`default_nettype none

package sfr_pkg;

  localparam int MAX_PATTERN_BYTES_DEF     = 8;
  localparam int MAX_REPLACEMENT_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH               = 4;
  localparam int CFG_INDEX_W               = 3;
  localparam int CFG_DATA_W                = 64;
  localparam int COUNT_W                   = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_BYTES      = 3'd0,
    REG_PATTERN_LENGTH     = 3'd1,
    REG_REPLACEMENT_BYTES  = 3'd2,
    REG_REPLACEMENT_LENGTH = 3'd3,
    REG_LIMIT_ENABLE       = 3'd4,
    REG_REPLACE_LIMIT      = 3'd5,
    REG_OUTPUT_LIMIT       = 3'd6
  } cfg_reg_t;

  // Flags of one command passed from the front end to the back end.
  typedef struct packed {
    logic replace;
    logic last;
  } sfr_flags_t;

endpackage

`default_nettype wire

// ===== design/sfr_front.sv =====
// Front end: keeps the match window and turns each input byte into one command.
`default_nettype none

module sfr_front
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  localparam int SEQ_BYTES = MAX_PATTERN_BYTES + 1,
  localparam int PASS_W    = $clog2(SEQ_BYTES + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   in_last,
  input  wire logic [63:0]            pattern_bytes,
  input  wire logic [3:0]             pattern_length,
  input  wire logic                   limit_enable,
  input  wire logic [COUNT_W-1:0]     replace_limit,
  output logic [SEQ_BYTES*8-1:0]      cmd_bytes,
  output logic [PASS_W-1:0]           cmd_pass,
  output sfr_flags_t                  cmd_flags
);

  localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

  logic [7:0]         window      [MAX_PATTERN_BYTES];
  logic [7:0]         window_next [MAX_PATTERN_BYTES];
  logic [7:0]         seq         [SEQ_BYTES];
  logic [FILL_W-1:0]  fill, fill_next;
  logic [COUNT_W-1:0] match_count, match_count_next;
  logic [PASS_W-1:0]  plen, fill_ext, seq_len, pre, held, pass, keep;
  logic               match_all, allowed, replace;
  logic [7:0]         cmp;

  always_comb begin
    fill_ext = PASS_W'(fill);
    seq_len  = fill_ext + PASS_W'(1);
    pre      = (fill_ext == PASS_W'(MAX_PATTERN_BYTES)) ? PASS_W'(1) : '0;
    held     = seq_len - pre;
    plen     = (pattern_length > 4'(MAX_PATTERN_BYTES)) ? PASS_W'(MAX_PATTERN_BYTES)
                                                        : PASS_W'(pattern_length);

    // Window bytes followed by the new byte, oldest first.
    for (int i = 0; i < SEQ_BYTES; i++) begin
      seq[i] = in_byte;
    end
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (PASS_W'(i) < fill_ext) begin
        seq[i] = window[i];
      end
    end

    // A full window drops its oldest byte first, so the compare starts one further on.
    match_all = 1'b1;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      cmp = (pre != '0) ? seq[i+1] : seq[i];
      if (PASS_W'(i) < plen && cmp != pattern_bytes[8*i +: 8]) begin
        match_all = 1'b0;
      end
    end

    allowed = !limit_enable || (match_count < replace_limit);
    replace = 1'b0;
    pass    = pre;
    keep    = held;
    if (held > plen) begin
      pass = seq_len - plen;
      keep = plen;
    end else if (held == plen) begin
      if (allowed && match_all) begin
        replace = 1'b1;
        keep    = '0;
      end else begin
        pass = pre + PASS_W'(1);
        keep = plen - PASS_W'(1);
      end
    end
    if (in_last) begin
      keep = '0;
      if (!replace) begin
        pass = seq_len;
      end
    end

    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      window_next[i] = seq[0];
      for (int j = 0; j < SEQ_BYTES; j++) begin
        if (int'(pass) + i == j) begin
          window_next[i] = seq[j];
        end
      end
    end

    fill_next = FILL_W'(keep);
    if (in_last) begin
      match_count_next = '0;
    end else if (replace && match_count != '1) begin
      match_count_next = match_count + COUNT_W'(1);
    end else begin
      match_count_next = match_count;
    end

    for (int i = 0; i < SEQ_BYTES; i++) begin
      cmd_bytes[8*i +: 8] = seq[i];
    end
    cmd_pass          = pass;
    cmd_flags.replace = replace;
    cmd_flags.last    = in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      match_count <= '0;
    end else if (accept) begin
      fill        <= fill_next;
      match_count <= match_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/sfr_queue.sv =====
// Small command queue between the front end and the back end.
`default_nettype none

module sfr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data,
  output logic                  head_valid,
  output logic                  full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;

  assign head_data  = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(DEPTH));

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/sfr_back.sv =====
// Back end: plays out each command one result per cycle, unless the output stalls.
`default_nettype none

module sfr_back
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES     = MAX_PATTERN_BYTES_DEF,
  parameter int MAX_REPLACEMENT_BYTES = MAX_REPLACEMENT_BYTES_DEF,
  localparam int SEQ_BYTES = MAX_PATTERN_BYTES + 1,
  localparam int PASS_W    = $clog2(SEQ_BYTES + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   head_valid,
  input  wire logic [SEQ_BYTES*8-1:0] head_bytes,
  input  wire logic [PASS_W-1:0]      head_pass,
  input  wire sfr_flags_t             head_flags,
  output logic                        pop,
  input  wire logic [63:0]            replacement_bytes,
  input  wire logic [3:0]             replacement_length,
  input  wire logic [COUNT_W-1:0]     output_limit,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  out_byte,
  output logic                        no_byte,
  output logic                        out_last
);

  localparam int RLEN_W = $clog2(MAX_REPLACEMENT_BYTES + 1);
  localparam int TOT_W  = $clog2(SEQ_BYTES + MAX_REPLACEMENT_BYTES + 1);

  logic [RLEN_W-1:0]  rlen;
  logic [TOT_W-1:0]   total, index, index_next;
  logic [COUNT_W-1:0] emitted, emitted_next;
  logic               out_free, go, none, final_byte, load;
  logic [7:0]         sel, byte_d;
  logic               no_byte_d, last_d;

  always_comb begin
    rlen = (replacement_length > 4'(MAX_REPLACEMENT_BYTES)) ? RLEN_W'(MAX_REPLACEMENT_BYTES)
                                                            : RLEN_W'(replacement_length);
    total    = TOT_W'(head_pass) + (head_flags.replace ? TOT_W'(rlen) : '0);
    out_free = !out_valid || !out_stall;
    go       = head_valid && out_free;
    // Nothing left to send for this command: empty, or the output budget is spent.
    none       = (emitted >= output_limit) || (total == '0);
    final_byte = (index + TOT_W'(1) == total) || (emitted + COUNT_W'(1) == output_limit);

    sel = 8'h00;
    if (index < TOT_W'(head_pass)) begin
      for (int j = 0; j < SEQ_BYTES; j++) begin
        if (index == TOT_W'(j)) begin
          sel = head_bytes[8*j +: 8];
        end
      end
    end else begin
      for (int j = 0; j < MAX_REPLACEMENT_BYTES; j++) begin
        if (index == TOT_W'(head_pass) + TOT_W'(j)) begin
          sel = replacement_bytes[8*j +: 8];
        end
      end
    end

    pop          = 1'b0;
    load         = 1'b0;
    index_next   = index;
    emitted_next = emitted;
    byte_d       = 8'h00;
    no_byte_d    = 1'b0;
    last_d       = 1'b0;
    if (go) begin
      if (none) begin
        pop        = 1'b1;
        index_next = '0;
        if (head_flags.last) begin
          load         = 1'b1;
          no_byte_d    = 1'b1;
          last_d       = 1'b1;
          emitted_next = '0;
        end
      end else begin
        load   = 1'b1;
        byte_d = sel;
        last_d = head_flags.last && final_byte;
        if (final_byte) begin
          pop          = 1'b1;
          index_next   = '0;
          emitted_next = head_flags.last ? '0 : emitted + COUNT_W'(1);
        end else begin
          index_next   = index + TOT_W'(1);
          emitted_next = emitted + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      index     <= '0;
      emitted   <= '0;
    end else begin
      index   <= index_next;
      emitted <= emitted_next;
      if (out_free) begin
        out_valid <= load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_d;
      no_byte  <= no_byte_d;
      out_last <= last_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/stream_find_replace.sv =====
// Top level of the stream find-and-replace block: configuration registers and the three stages.
`default_nettype none

// The block takes a byte stream, one byte per input transaction, and replaces each
// non-overlapping occurrence of the configured pattern (up to MAX_PATTERN_BYTES long)
// with the configured replacement, scanning leftmost-first. The front end takes one byte
// every clock cycle while the queue has room and updates the match window in that same
// cycle, so input is never stalled by the matching itself. Each byte becomes one command
// in a QUEUE_DEPTH-entry queue; the back end turns a command into zero or more result
// transactions (a replacement burst or a flush at the end of a stream gives several)
// at one per cycle while the output is not stalled, through a single output register.
// The input stalls only when that queue is full. The first result caused by an accepted
// byte passes through the queue and then the output register before it can be taken.
// Configuration must be written through the write port only while the block is idle;
// the block itself does not enforce this. A stream's match count, window and output
// byte count start over after each transaction marked last.

module stream_find_replace
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES     = MAX_PATTERN_BYTES_DEF,
  parameter int MAX_REPLACEMENT_BYTES = MAX_REPLACEMENT_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Configuration write port.
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // Input stream.
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   in_last,
  // Result stream.
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  out_byte,
  output logic                        no_byte,
  output logic                        out_last
);

  localparam int SEQ_BYTES = MAX_PATTERN_BYTES + 1;
  localparam int PASS_W    = $clog2(SEQ_BYTES + 1);
  localparam int FLAGS_W   = $bits(sfr_flags_t);
  localparam int ENTRY_W   = SEQ_BYTES * 8 + PASS_W + FLAGS_W;

  // Configuration registers, reset to their documented defaults.
  logic [63:0]        pattern_bytes;
  logic [3:0]         pattern_length;
  logic [63:0]        replacement_bytes;
  logic [3:0]         replacement_length;
  logic               limit_enable;
  logic [COUNT_W-1:0] replace_limit;
  logic [COUNT_W-1:0] output_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
      limit_enable       <= 1'b0;
      replace_limit      <= '0;
      output_limit       <= '1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data[63:0];
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data[63:0];
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
        REG_LIMIT_ENABLE:       limit_enable       <= cfg_data[0];
        REG_REPLACE_LIMIT:      replace_limit      <= cfg_data[COUNT_W-1:0];
        REG_OUTPUT_LIMIT:       output_limit       <= cfg_data[COUNT_W-1:0];
        default: begin
          // Writes to an unused index are ignored.
        end
      endcase
    end
  end

  // An input transaction is taken whenever the command queue has room.
  logic                   accept;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  logic [ENTRY_W-1:0]     q_head;
  logic [SEQ_BYTES*8-1:0] cmd_bytes;
  logic [PASS_W-1:0]      cmd_pass;
  sfr_flags_t             cmd_flags;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // The front end decides, per byte, how many of the window bytes leave in order and
  // whether a replacement follows them; the bytes themselves ride along in the command.
  sfr_front #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .pattern_bytes  (pattern_bytes),
    .pattern_length (pattern_length),
    .limit_enable   (limit_enable),
    .replace_limit  (replace_limit),
    .cmd_bytes      (cmd_bytes),
    .cmd_pass       (cmd_pass),
    .cmd_flags      (cmd_flags)
  );

  sfr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  ({cmd_bytes, cmd_pass, cmd_flags}),
    .pop        (q_pop),
    .head_data  (q_head),
    .head_valid (q_valid),
    .full       (q_full)
  );

  // The back end applies the output byte limit and marks the end of each stream.
  sfr_back #(
    .MAX_PATTERN_BYTES     (MAX_PATTERN_BYTES),
    .MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .head_valid         (q_valid),
    .head_bytes         (q_head[ENTRY_W-1 -: SEQ_BYTES*8]),
    .head_pass          (q_head[FLAGS_W +: PASS_W]),
    .head_flags         (sfr_flags_t'(q_head[FLAGS_W-1:0])),
    .pop                (q_pop),
    .replacement_bytes  (replacement_bytes),
    .replacement_length (replacement_length),
    .output_limit       (output_limit),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .no_byte            (no_byte),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

// ===== design/sfr_checker.sv =====
// Port-level checks for the stream find-and-replace block, bound to its top level.
`default_nettype none

module sfr_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       no_byte,
  input wire logic       out_last
);

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(no_byte)
                               && $stable(out_last))
    else $error("result changed while stalled");

  // A result without a byte only closes a stream and carries a zero byte.
  a_no_byte_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_byte |-> out_last && out_byte == 8'h00)
    else $error("empty result not marked last");

  // Reset leaves no result pending and the input open.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset did not clear the block");

  // With the queue full and the output empty, the back end must make progress.
  a_progress: assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_valid |=> !in_stall || out_valid)
    else $error("back end idle while input is stalled");

  // The input can only fill up after a transaction was offered.
  a_stall_needs_input: assert property (@(posedge clk) disable iff (rst)
    !in_stall && !in_valid |=> !in_stall)
    else $error("input stalled with nothing offered");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .no_byte   (no_byte),
  .out_last  (out_last)
);

`default_nettype wire

// ===== bench/stream_find_replace_tb.sv =====
// Self-checking testbench for the stream find-and-replace block with its own byte-level predictor.
module stream_find_replace_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  // One result transaction as the predictor expects it on the output channel.
  typedef struct {
    logic [7:0] text;
    logic       empty;
    logic       last;
  } text_result_t;

  localparam int WIN_BYTES = MAX_PATTERN_BYTES_DEF;
  localparam int REP_BYTES = MAX_REPLACEMENT_BYTES_DEF;

  // Ports of the block. Every input holds a known value from time zero.
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_byte   = 8'h00;
  logic                   in_last   = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_byte;
  logic                   no_byte;
  logic                   out_last;

  // Idle rates in percent per cycle for the sender and the receiver, and the receiver
  // hold-off request that the pressure test hands to the receiver process.
  int unsigned in_idle_pct  = 29;
  int unsigned out_idle_pct = 29;
  int          hold_request = 0;
  int          hold_left    = 0;
  int          fail_count   = 0;
  int unsigned bytes_sent   = 0;

  // Results still owed by the block, oldest first.
  text_result_t expected_text[$];

  // Mirror of the configuration registers.
  logic [63:0] pattern;
  logic [3:0]  pattern_len;
  logic [63:0] replacement;
  logic [3:0]  replacement_len;
  logic        limit_on;
  logic [15:0] replace_limit;
  logic [15:0] out_limit;

  // Mirror of the matcher state: the window of recent bytes (oldest in entry 0), how many
  // entries are in use, and the per-stream match and output byte counts.
  logic [7:0]  window [WIN_BYTES];
  int          window_fill;
  int          match_count;
  int          bytes_out;
  int          step_results;

  stream_find_replace i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .no_byte   (no_byte),
    .out_last  (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor. It follows the block one accepted byte at a time and appends the result
  // transactions that byte causes to expected_text.
  // ---------------------------------------------------------------------------------------

  function automatic void reset_matcher();
    pattern         = '0;
    pattern_len     = '0;
    replacement     = '0;
    replacement_len = '0;
    limit_on        = 1'b0;
    replace_limit   = '0;
    out_limit       = 16'hFFFF;
    foreach (window[i]) window[i] = 8'h00;
    window_fill = 0;
    match_count = 0;
    bytes_out   = 0;
  endfunction

  // A byte leaves the block only while the stream is under its output limit; past the
  // limit it is silently dropped.
  function automatic void emit_text(logic [7:0] b);
    text_result_t r;
    if (bytes_out < out_limit) begin
      r.text  = b;
      r.empty = 1'b0;
      r.last  = 1'b0;
      expected_text.push_back(r);
      bytes_out++;
      step_results++;
    end
  endfunction

  function automatic void pass_oldest_byte();
    if (window_fill == 0) return;
    emit_text(window[0]);
    for (int i = 0; i < WIN_BYTES - 1; i++) window[i] = window[i + 1];
    window_fill--;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic last);
    int           plen;
    int           rlen;
    bit           hit;
    text_result_t end_mark;
    // Lengths above the window or replacement size saturate.
    plen = (pattern_len > WIN_BYTES) ? WIN_BYTES : int'(pattern_len);
    rlen = (replacement_len > REP_BYTES) ? REP_BYTES : int'(replacement_len);
    step_results = 0;

    if (window_fill >= WIN_BYTES) pass_oldest_byte();
    window[window_fill] = b;
    window_fill++;

    if (window_fill > plen) begin
      // Covers pass-through with no pattern, and a window left longer than a pattern
      // that was shortened mid-stream: the surplus goes out and nothing is compared.
      while (window_fill > plen) pass_oldest_byte();
    end else if (window_fill == plen) begin
      hit = !limit_on || (match_count < replace_limit);
      for (int i = 0; i < plen; i++) begin
        if (window[i] != pattern[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (int k = 0; k < rlen; k++) emit_text(replacement[8*k +: 8]);
        window_fill = 0;
        if (match_count < 65535) match_count++;
      end else begin
        pass_oldest_byte();
      end
    end

    if (last) begin
      while (window_fill > 0) pass_oldest_byte();
      match_count = 0;
      bytes_out   = 0;
      // A stream end that carries no byte still needs a marker transaction.
      if (step_results == 0) begin
        end_mark.text  = 8'h00;
        end_mark.empty = 1'b1;
        end_mark.last  = 1'b1;
        expected_text.push_back(end_mark);
      end else begin
        expected_text[expected_text.size() - 1].last = 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Receiver. It stalls at random, or for a whole hold-off stretch when one is requested.
  // ---------------------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result checker. Every accepted result transaction is held against the oldest
  // expectation. Values are sampled at the edge, before any of that edge's updates.
  // ---------------------------------------------------------------------------------------

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    text_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result, expected none, actual byte %02h no_byte %0b last %0b",
                 $time, out_byte, no_byte, out_last);
      end else begin
        want = expected_text.pop_front();
        check_field("out_byte", want.text, out_byte);
        check_field("no_byte", want.empty, no_byte);
        check_field("out_last", want.last, out_last);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Shared drivers. All of them are entered right after a rising edge and drive inputs
  // with nonblocking assignments, so the block sees them at the following edge.
  // ---------------------------------------------------------------------------------------

  // Offers one byte, with random idle cycles ahead of it, and waits until the transaction
  // is taken. Valid stays high on return so that a following byte goes back to back.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_text(input logic [7:0] text[$], input bit ends);
    foreach (text[i]) send_byte(text[i], ends && (i == text.size() - 1));
  endtask

  // Lets every owed result drain, then waits out commands that cause no result and may
  // still sit in the block's queue.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // One register write. The write enable is left high so that writes go back to back.
  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_PATTERN_BYTES:      pattern         = val;
      REG_PATTERN_LENGTH:     pattern_len     = val[3:0];
      REG_REPLACEMENT_BYTES:  replacement     = val;
      REG_REPLACEMENT_LENGTH: replacement_len = val[3:0];
      REG_LIMIT_ENABLE:       limit_on        = val[0];
      REG_REPLACE_LIMIT:      replace_limit   = val[15:0];
      REG_OUTPUT_LIMIT:       out_limit       = val[15:0];
      default: ;
    endcase
  endtask

  // Writes the whole register set once the block has gone idle.
  task automatic load_settings(input logic [63:0] pat, input logic [3:0] plen,
                               input logic [63:0] rep, input logic [3:0] rlen,
                               input logic lim_on, input logic [15:0] lim,
                               input logic [15:0] olim);
    settle();
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_PATTERN_LENGTH, 64'(plen));
    write_reg(REG_REPLACEMENT_BYTES, rep);
    write_reg(REG_REPLACEMENT_LENGTH, 64'(rlen));
    write_reg(REG_LIMIT_ENABLE, 64'(lim_on));
    write_reg(REG_REPLACE_LIMIT, 64'(lim));
    write_reg(REG_OUTPUT_LIMIT, 64'(olim));
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // Straight after reset there is no pattern, so bytes come out unchanged.
  task automatic test_pass_through();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Pattern "ab" becomes "XYZ"; a leading 'a' that fails the match is passed on.
  task automatic test_basic_replace();
    load_settings(64'h6261, 4'd2, 64'h5A5958, 4'd3, 1'b0, 16'd0, 16'hFFFF);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(8'h62, 1'b1);
  endtask

  // Both lengths written above the maximum saturate: an all-ones pattern of eight bytes
  // turns into eight zero bytes, and the byte after it is flushed at the stream end.
  task automatic test_extremes();
    load_settings('1, 4'd15, 64'h0, 4'd15, 1'b0, 16'hFFFF, 16'hFFFF);
    repeat (8) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Streams that end with nothing to send: a match deleted by an empty replacement, and
  // an output limit of zero that drops every byte.
  task automatic test_empty_end();
    load_settings(64'h61, 4'd1, 64'h0, 4'd0, 1'b0, 16'd0, 16'hFFFF);
    send_byte(8'h61, 1'b1);
    load_settings(64'h0, 4'd0, 64'h0, 4'd0, 1'b0, 16'd0, 16'd0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
  endtask

  // Only the first match is replaced, and the output limit of three cuts the stream.
  task automatic test_limits();
    load_settings(64'h61, 4'd1, 64'h62, 4'd1, 1'b1, 16'd1, 16'd3);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h63, 1'b1);
  endtask

  // Three bytes wait in the window for a four-byte pattern; the pattern is then cut to
  // one byte, so the next byte pushes the waiting ones out without a comparison.
  task automatic test_shortened_pattern();
    load_settings(64'h64636261, 4'd4, 64'h58, 4'd1, 1'b0, 16'd0, 16'hFFFF);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    load_settings(64'h7A, 4'd1, 64'h58, 4'd1, 1'b0, 16'd0, 16'hFFFF);
    send_byte(8'h71, 1'b1);
  endtask

  // Random settings, each followed by a few streams. Most of the text is built from the
  // pattern itself (whole copies, partial copies, its own bytes) so that matches, near
  // misses and overlaps are common; the rest is arbitrary bytes. Now and then a phase
  // ends in the middle of a stream, so the next settings meet a partly filled window.
  task automatic test_random_streams(input int unsigned target);
    logic [63:0] pat;
    logic [63:0] rep;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [7:0]  text[$];
    logic [15:0] lim;
    logic [15:0] olim;
    logic [3:0]  plen;
    int          eff;
    int          nstreams;
    int          len;
    int          r;
    int          k;
    bit          ends;
    while (bytes_sent < target) begin
      a0 = 8'($urandom_range(255));
      a1 = 8'($urandom_range(255));
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(99) < 20) pat[8*i +: 8] = 8'($urandom_range(255));
        else pat[8*i +: 8] = $urandom_range(1) ? a0 : a1;
      end
      rep = {$urandom, $urandom};
      r = $urandom_range(99);
      if (r < 10) plen = 4'd0;
      else if (r < 60) plen = 4'($urandom_range(1, 3));
      else if (r < 85) plen = 4'($urandom_range(4, 8));
      else plen = 4'($urandom_range(9, 15));
      eff  = (plen > WIN_BYTES) ? WIN_BYTES : int'(plen);
      lim  = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(4));
      olim = ($urandom_range(99) < 70) ? 16'hFFFF : 16'($urandom_range(12));
      load_settings(pat, plen, rep, 4'($urandom_range(15)), 1'($urandom_range(1)), lim, olim);

      nstreams = $urandom_range(2, 5);
      for (int s = 0; s < nstreams; s++) begin
        text.delete();
        len = $urandom_range(1, 20);
        while (text.size() < len) begin
          r = $urandom_range(99);
          if (r < 35 && eff > 0) begin
            k = ($urandom_range(3) == 0) ? $urandom_range(1, eff) : eff;
            for (int i = 0; i < k; i++) text.push_back(pat[8*i +: 8]);
          end else if (r < 80) begin
            text.push_back(pat[8*$urandom_range(7) +: 8]);
          end else begin
            text.push_back(8'($urandom_range(255)));
          end
        end
        ends = !(s == nstreams - 1 && $urandom_range(99) < 20);
        send_text(text, ends);
      end
    end
  endtask

  // A one-byte pattern that expands to eight bytes, with the receiver held off for a long
  // stretch while the sender keeps offering, so the block's queue fills and it stalls its
  // input. A second stream then runs with no idling on either side.
  task automatic test_backpressure();
    logic [7:0] text[$];
    in_idle_pct  = 0;
    out_idle_pct = 0;
    load_settings(64'h00, 4'd1, {$urandom, $urandom}, 4'd8, 1'b0, 16'd0, 16'hFFFF);
    for (int i = 0; i < 40; i++)
      text.push_back(($urandom_range(99) < 75) ? 8'h00 : 8'($urandom_range(255)));
    hold_request = 120;
    send_text(text, 1'b1);
    text.delete();
    for (int i = 0; i < 30; i++)
      text.push_back(($urandom_range(99) < 40) ? 8'h00 : 8'($urandom_range(255)));
    send_text(text, 1'b1);
    in_idle_pct  = 29;
    out_idle_pct = 29;
  endtask

  initial begin
    reset_matcher();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_pass_through();
    test_basic_replace();
    test_extremes();
    test_empty_end();
    test_limits();
    test_shortened_pattern();
    test_random_streams(220);
    test_backpressure();

    settle();
    if (fail_count == 0 && expected_text.size() == 0) begin
      $display("stream_find_replace test passed");
    end else begin
      $display("stream_find_replace test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #400000;
    $display("stream_find_replace test failed");
    $finish;
  end

endmodule
